@@ src/nls_pkg.sv @@
// Shared types and constants for the numeric literal scanner.
package nls_pkg;

   localparam int VALUE_BITS_DEF      = 64;
   localparam int MAX_FRAC_DIGITS_DEF = 18;
   localparam int QUEUE_DEPTH         = 2;

   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int VALUE_W  = 64;
   localparam int FRAC_W   = 5;
   localparam int STATUS_W = 2;
   localparam int GIVE_W   = 2;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_B = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DIGIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FRAC_OVF  = 2'd2;

   localparam logic [GIVE_W-1:0] GIVE_NONE = 2'd0;
   localparam logic [GIVE_W-1:0] GIVE_TERM = 2'd1;
   localparam logic [GIVE_W-1:0] GIVE_DOT  = 2'd2;

   typedef struct packed {
      logic               end_flag;
      logic               is_digit;
      logic               is_dec;
      logic               is_zero;
      logic               is_b;
      logic               is_x;
      logic               is_under;
      logic               is_dot;
      logic [DIGIT_W-1:0] digit;
   } class_type;

endpackage

@@ src/nls_front.sv @@
// Front stage: accept a character item and register its classification.
module nls_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [nls_pkg::CHAR_W-1:0]   req_ch,
   input  logic                         req_end_of_input,
   output logic                         cls_valid,
   input  logic                         cls_ready,
   output nls_pkg::class_type           cls_data
);

   logic               valid_ff;
   nls_pkg::class_type cls_ff;
   nls_pkg::class_type cls_in;
   logic               is_num;
   logic               is_hex;

   always_comb begin
      is_num          = (req_ch >= nls_pkg::CH_ZERO) && (req_ch <= nls_pkg::CH_NINE);
      is_hex          = (req_ch >= nls_pkg::CH_LOW_A) && (req_ch <= nls_pkg::CH_LOW_F);
      cls_in.end_flag = req_end_of_input;
      cls_in.is_dec   = is_num;
      cls_in.is_digit = is_num || is_hex;
      cls_in.is_zero  = (req_ch == nls_pkg::CH_ZERO);
      cls_in.is_b     = (req_ch == nls_pkg::CH_LOW_B);
      cls_in.is_x     = (req_ch == nls_pkg::CH_LOW_X);
      cls_in.is_under = (req_ch == nls_pkg::CH_UNDER);
      cls_in.is_dot   = (req_ch == nls_pkg::CH_DOT);
      if (is_num) begin
         cls_in.digit = nls_pkg::DIGIT_W'(req_ch - nls_pkg::CH_ZERO);
      end else begin
         cls_in.digit = nls_pkg::DIGIT_W'(req_ch - nls_pkg::CH_LOW_A + 8'd10);
      end
   end

   assign req_stall = valid_ff && !cls_ready;
   assign cls_valid = valid_ff;
   assign cls_data  = cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || cls_ready) begin
         valid_ff <= req_valid;
      end
      if (!valid_ff || cls_ready) begin
         cls_ff <= cls_in;
      end
   end

endmodule

@@ src/nls_queue.sv @@
// Short item queue between the front and back stages.
module nls_queue #(
   parameter int DEPTH = nls_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  nls_pkg::class_type push_data,
   output logic               pop_valid,
   input  logic               pop_take,
   output nls_pkg::class_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   nls_pkg::class_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/nls_back.sv @@
// Back stage: scan state machine, accumulator and result register.
module nls_back #(
   parameter int VALUE_BITS      = nls_pkg::VALUE_BITS_DEF,
   parameter int MAX_FRAC_DIGITS = nls_pkg::MAX_FRAC_DIGITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cls_valid,
   output logic                               cls_take,
   input  nls_pkg::class_type                 cls_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nls_pkg::VALUE_W-1:0] rsp_value,
   output logic [nls_pkg::FRAC_W-1:0]         rsp_frac_digits,
   output logic                               rsp_is_fixed,
   output logic [nls_pkg::STATUS_W-1:0]       rsp_status,
   output logic [nls_pkg::GIVE_W-1:0]         rsp_give_back
);

   typedef enum logic [2:0] {
      MODE_START,
      MODE_ZERO,
      MODE_INT,
      MODE_DOT,
      MODE_FRAC
   } mode_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_BIN,
      RADIX_HEX
   } radix_type;

   mode_type                        mode_ff, mode_in;
   radix_type                       radix_ff, radix_in;
   logic [VALUE_BITS-1:0]           accum_ff, accum_in;
   logic [nls_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic                            rsp_valid_ff;
   logic signed [nls_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [nls_pkg::FRAC_W-1:0]      frac_out_ff, frac_out_in;
   logic                            fixed_ff, fixed_in;
   logic [nls_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [nls_pkg::GIVE_W-1:0]      give_ff, give_in;

   logic                            take;
   logic                            emit;
   logic                            ok;
   logic                            do_int;
   logic                            digit_ok;
   radix_type                       eff_radix;
   radix_type                       mul_radix;
   logic [VALUE_BITS-1:0]           eff_acc;
   logic [nls_pkg::FRAC_W-1:0]      eff_frac;
   logic [VALUE_BITS-1:0]           scaled;
   logic [VALUE_BITS-1:0]           mac;

   assign take     = cls_valid && (!rsp_valid_ff || !rsp_stall);
   assign cls_take = take;

   always_comb begin
      eff_acc   = (mode_ff == MODE_START) ? '0 : accum_ff;
      eff_radix = (mode_ff == MODE_START) ? RADIX_DEC : radix_ff;
      eff_frac  = (mode_ff == MODE_START) ? '0 : frac_ff;
      mul_radix = (mode_ff == MODE_DOT || mode_ff == MODE_FRAC) ? RADIX_DEC : eff_radix;
      unique case (mul_radix)
         RADIX_BIN: scaled = eff_acc << 1;
         RADIX_HEX: scaled = eff_acc << 4;
         default:   scaled = (eff_acc << 3) + (eff_acc << 1);
      endcase
      mac = scaled + VALUE_BITS'(cls_data.digit);
      unique case (eff_radix)
         RADIX_BIN: digit_ok = (cls_data.digit < 4'd2);
         RADIX_HEX: digit_ok = 1'b1;
         default:   digit_ok = (cls_data.digit < 4'd10);
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      radix_in  = radix_ff;
      accum_in  = accum_ff;
      frac_in   = frac_ff;
      emit      = 1'b0;
      ok        = 1'b1;
      do_int    = 1'b0;
      status_in = nls_pkg::STATUS_OK;
      give_in   = nls_pkg::GIVE_NONE;
      fixed_in  = 1'b0;
      if (take) begin
         unique case (mode_ff)
            MODE_START: begin
               if (!cls_data.end_flag) begin
                  radix_in = RADIX_DEC;
                  accum_in = '0;
                  frac_in  = '0;
                  if (cls_data.is_zero) begin
                     mode_in = MODE_ZERO;
                  end else begin
                     do_int = 1'b1;
                  end
               end
            end
            MODE_ZERO: begin
               if (cls_data.end_flag) begin
                  emit = 1'b1;
               end else if (cls_data.is_b) begin
                  radix_in = RADIX_BIN;
                  mode_in  = MODE_INT;
               end else if (cls_data.is_x) begin
                  radix_in = RADIX_HEX;
                  mode_in  = MODE_INT;
               end else begin
                  do_int = 1'b1;
               end
            end
            MODE_INT: begin
               if (cls_data.end_flag) begin
                  emit = 1'b1;
               end else begin
                  do_int = 1'b1;
               end
            end
            MODE_DOT: begin
               if (cls_data.end_flag) begin
                  emit    = 1'b1;
                  give_in = nls_pkg::GIVE_TERM;
               end else if (cls_data.is_dec) begin
                  accum_in = mac;
                  frac_in  = nls_pkg::FRAC_W'(1);
                  mode_in  = MODE_FRAC;
               end else begin
                  emit    = 1'b1;
                  give_in = nls_pkg::GIVE_DOT;
               end
            end
            MODE_FRAC: begin
               if (cls_data.end_flag) begin
                  emit     = 1'b1;
                  fixed_in = 1'b1;
               end else if (cls_data.is_dec) begin
                  if (frac_ff >= nls_pkg::FRAC_W'(MAX_FRAC_DIGITS)) begin
                     emit      = 1'b1;
                     ok        = 1'b0;
                     status_in = nls_pkg::STATUS_FRAC_OVF;
                  end else begin
                     accum_in = mac;
                     frac_in  = frac_ff + 1'b1;
                  end
               end else begin
                  emit     = 1'b1;
                  fixed_in = 1'b1;
                  give_in  = nls_pkg::GIVE_TERM;
               end
            end
            default: begin
               mode_in  = MODE_START;
               radix_in = RADIX_DEC;
               accum_in = '0;
               frac_in  = '0;
            end
         endcase
         if (do_int) begin
            mode_in = MODE_INT;
            if (cls_data.is_under) begin
               mode_in = MODE_INT;
            end else if (!cls_data.is_digit) begin
               if (eff_radix == RADIX_DEC && cls_data.is_dot) begin
                  mode_in = MODE_DOT;
               end else begin
                  emit    = 1'b1;
                  give_in = nls_pkg::GIVE_TERM;
               end
            end else if (!digit_ok) begin
               emit      = 1'b1;
               ok        = 1'b0;
               status_in = nls_pkg::STATUS_BAD_DIGIT;
            end else begin
               accum_in = mac;
            end
         end
         if (emit) begin
            mode_in  = MODE_START;
            radix_in = RADIX_DEC;
            accum_in = '0;
            frac_in  = '0;
         end
      end
      if (ok) begin
         value_in    = nls_pkg::VALUE_W'($signed(eff_acc));
         frac_out_in = eff_frac;
      end else begin
         value_in    = '0;
         frac_out_in = '0;
         fixed_in    = 1'b0;
         give_in     = nls_pkg::GIVE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         radix_ff     <= RADIX_DEC;
         accum_ff     <= '0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         radix_ff <= radix_in;
         accum_ff <= accum_in;
         frac_ff  <= frac_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         value_ff    <= value_in;
         frac_out_ff <= frac_out_in;
         fixed_ff    <= fixed_in;
         status_ff   <= status_in;
         give_ff     <= give_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = value_ff;
   assign rsp_frac_digits = frac_out_ff;
   assign rsp_is_fixed    = fixed_ff;
   assign rsp_status      = status_ff;
   assign rsp_give_back   = give_ff;

endmodule

@@ src/numeric_literal_scanner.sv @@
// Top level of the numeric literal scanner: front, queue and back stages.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/req_stall req_ch, req_end_of_input
//   rsp       out        rsp_valid/rsp_stall rsp_value, rsp_frac_digits, rsp_is_fixed,
//                                            rsp_status, rsp_give_back
//
// One character item per cycle sustained while rsp is not stalled; the accumulator
// multiply-add in the back stage (shift-and-add by 2, 10 or 16) is the one step each item needs.
// A result for the item that ends the literal reaches rsp through the front register
// at its accepting edge, then a queue slot, then the result register.
// Reset is synchronous; no clearing pass.
// A stalled result holds in the result register; the queue lets the front keep
// accepting until it fills, then req_stall rises.
module numeric_literal_scanner #(
   parameter int VALUE_BITS      = nls_pkg::VALUE_BITS_DEF,
   parameter int MAX_FRAC_DIGITS = nls_pkg::MAX_FRAC_DIGITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [nls_pkg::CHAR_W-1:0]         req_ch,
   input  logic                               req_end_of_input,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nls_pkg::VALUE_W-1:0] rsp_value,
   output logic [nls_pkg::FRAC_W-1:0]         rsp_frac_digits,
   output logic                               rsp_is_fixed,
   output logic [nls_pkg::STATUS_W-1:0]       rsp_status,
   output logic [nls_pkg::GIVE_W-1:0]         rsp_give_back
);

   logic               front_valid;
   logic               front_ready;
   nls_pkg::class_type front_data;
   logic               queue_valid;
   logic               queue_take;
   nls_pkg::class_type queue_data;

   nls_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .cls_valid        (front_valid),
      .cls_ready        (front_ready),
      .cls_data         (front_data)
   );

   nls_queue #(
      .DEPTH (nls_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_take   (queue_take),
      .pop_data   (queue_data)
   );

   nls_back #(
      .VALUE_BITS      (VALUE_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cls_valid       (queue_valid),
      .cls_take        (queue_take),
      .cls_data        (queue_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_frac_digits (rsp_frac_digits),
      .rsp_is_fixed    (rsp_is_fixed),
      .rsp_status      (rsp_status),
      .rsp_give_back   (rsp_give_back)
   );

endmodule

@@ tb/numeric_literal_scanner_test.sv @@
// Self-checking testbench for numeric_literal_scanner: directed table, then random literals.
module numeric_literal_scanner_test;

   localparam int DIRECTED_N   = 23;
   localparam int RANDOM_ITEMS = 850;
   localparam int PAUSE_AT     = DIRECTED_N + 400;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_LIMIT  = 5000;

   typedef enum logic [2:0] {
      SCAN_START, SCAN_ZERO, SCAN_INT, SCAN_DOT, SCAN_FRAC
   } scan_mode_type;
   typedef enum logic [1:0] {RADIX_DEC, RADIX_BIN, RADIX_HEX} radix_type;

   typedef struct packed {
      logic signed [nls_pkg::VALUE_W-1:0] value;
      logic [nls_pkg::FRAC_W-1:0]         frac_digits;
      logic                               is_fixed;
      logic [nls_pkg::STATUS_W-1:0]       status;
      logic [nls_pkg::GIVE_W-1:0]         give_back;
   } literal_type;

   typedef struct packed {
      logic [nls_pkg::CHAR_W-1:0] ch;
      logic                       eoi;
      logic                       typed;
      literal_type                want;
   } char_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [nls_pkg::CHAR_W-1:0]         req_ch = '0;
   logic                               req_end_of_input = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [nls_pkg::VALUE_W-1:0] rsp_value;
   logic [nls_pkg::FRAC_W-1:0]         rsp_frac_digits;
   logic                               rsp_is_fixed;
   logic [nls_pkg::STATUS_W-1:0]       rsp_status;
   logic [nls_pkg::GIVE_W-1:0]         rsp_give_back;

   scan_mode_type              mode_q = SCAN_START;
   radix_type                  radix_q = RADIX_DEC;
   logic [63:0]                accum_q = '0;
   logic [nls_pkg::FRAC_W-1:0] frac_q = '0;

   literal_type  pending_literals[$];
   char_row_type char_stream[$];
   char_row_type directed_rows[DIRECTED_N];
   int unsigned  mismatches = 0;
   bit           tx_calm = 1'b0;
   bit           rx_calm = 1'b0;

   numeric_literal_scanner u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_frac_digits  (rsp_frac_digits),
      .rsp_is_fixed     (rsp_is_fixed),
      .rsp_status       (rsp_status),
      .rsp_give_back    (rsp_give_back)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0) tx_calm <= !tx_calm;
      if ($urandom_range(0, 149) == 0) rx_calm <= !rx_calm;
   end

   function automatic int unsigned idle_cycles(bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [4:0] digit_of(logic [nls_pkg::CHAR_W-1:0] c);
      if (c >= nls_pkg::CH_ZERO && c <= nls_pkg::CH_NINE) return 5'(c - nls_pkg::CH_ZERO);
      if (c >= nls_pkg::CH_LOW_A && c <= nls_pkg::CH_LOW_F) begin
         return 5'(c - nls_pkg::CH_LOW_A + 8'd10);
      end
      return 5'd16;
   endfunction

   function automatic literal_type close_literal(bit ok, logic [nls_pkg::STATUS_W-1:0] st,
                                                 logic [nls_pkg::GIVE_W-1:0] give);
      literal_type r;
      r.value       = ok ? accum_q : '0;
      r.frac_digits = ok ? frac_q : '0;
      r.is_fixed    = ok && (mode_q == SCAN_FRAC);
      r.status      = st;
      r.give_back   = ok ? give : nls_pkg::GIVE_NONE;
      mode_q  = SCAN_START;
      radix_q = RADIX_DEC;
      accum_q = '0;
      frac_q  = '0;
      return r;
   endfunction

   function automatic bit scan_integer(logic [nls_pkg::CHAR_W-1:0] c, output literal_type r);
      logic [63:0] base;
      logic [63:0] d;
      base = (radix_q == RADIX_BIN) ? 64'd2 : (radix_q == RADIX_HEX) ? 64'd16 : 64'd10;
      d = 64'(digit_of(c));
      mode_q = SCAN_INT;
      if (c == nls_pkg::CH_UNDER) return 1'b0;
      if (d == 64'd16) begin
         if (radix_q == RADIX_DEC && c == nls_pkg::CH_DOT) begin
            mode_q = SCAN_DOT;
            return 1'b0;
         end
         r = close_literal(1'b1, nls_pkg::STATUS_OK, nls_pkg::GIVE_TERM);
         return 1'b1;
      end
      if (d >= base) begin
         r = close_literal(1'b0, nls_pkg::STATUS_BAD_DIGIT, nls_pkg::GIVE_NONE);
         return 1'b1;
      end
      accum_q = accum_q * base + d;
      return 1'b0;
   endfunction

   function automatic bit scan_char(logic [nls_pkg::CHAR_W-1:0] c, logic eoi,
                                    output literal_type r);
      bit dec_digit;
      dec_digit = (c >= nls_pkg::CH_ZERO && c <= nls_pkg::CH_NINE);
      case (mode_q)
         SCAN_START: begin
            if (eoi) return 1'b0;
            accum_q = '0;
            radix_q = RADIX_DEC;
            frac_q  = '0;
            if (c == nls_pkg::CH_ZERO) begin
               mode_q = SCAN_ZERO;
               return 1'b0;
            end
            return scan_integer(c, r);
         end
         SCAN_ZERO: begin
            if (eoi) begin
               r = close_literal(1'b1, nls_pkg::STATUS_OK, nls_pkg::GIVE_NONE);
               return 1'b1;
            end
            if (c == nls_pkg::CH_LOW_B || c == nls_pkg::CH_LOW_X) begin
               radix_q = (c == nls_pkg::CH_LOW_B) ? RADIX_BIN : RADIX_HEX;
               mode_q  = SCAN_INT;
               return 1'b0;
            end
            return scan_integer(c, r);
         end
         SCAN_INT: begin
            if (eoi) begin
               r = close_literal(1'b1, nls_pkg::STATUS_OK, nls_pkg::GIVE_NONE);
               return 1'b1;
            end
            return scan_integer(c, r);
         end
         SCAN_DOT: begin
            if (eoi) begin
               mode_q = SCAN_INT;
               r = close_literal(1'b1, nls_pkg::STATUS_OK, nls_pkg::GIVE_TERM);
               return 1'b1;
            end
            if (dec_digit) begin
               accum_q = accum_q * 64'd10 + 64'(c - nls_pkg::CH_ZERO);
               frac_q  = 5'd1;
               mode_q  = SCAN_FRAC;
               return 1'b0;
            end
            mode_q = SCAN_INT;
            r = close_literal(1'b1, nls_pkg::STATUS_OK, nls_pkg::GIVE_DOT);
            return 1'b1;
         end
         SCAN_FRAC: begin
            if (eoi) begin
               r = close_literal(1'b1, nls_pkg::STATUS_OK, nls_pkg::GIVE_NONE);
               return 1'b1;
            end
            if (dec_digit) begin
               if (int'(frac_q) >= nls_pkg::MAX_FRAC_DIGITS_DEF) begin
                  r = close_literal(1'b0, nls_pkg::STATUS_FRAC_OVF, nls_pkg::GIVE_NONE);
                  return 1'b1;
               end
               accum_q = accum_q * 64'd10 + 64'(c - nls_pkg::CH_ZERO);
               frac_q  = frac_q + 5'd1;
               return 1'b0;
            end
            r = close_literal(1'b1, nls_pkg::STATUS_OK, nls_pkg::GIVE_TERM);
            return 1'b1;
         end
         default: begin
            mode_q  = SCAN_START;
            radix_q = RADIX_DEC;
            accum_q = '0;
            frac_q  = '0;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic literal_type ok_literal(logic signed [nls_pkg::VALUE_W-1:0] v,
                                              logic [nls_pkg::GIVE_W-1:0] give);
      literal_type r;
      r = '0;
      r.value     = v;
      r.status    = nls_pkg::STATUS_OK;
      r.give_back = give;
      return r;
   endfunction

   function automatic literal_type bad_literal(logic [nls_pkg::STATUS_W-1:0] st);
      literal_type r;
      r = '0;
      r.status = st;
      return r;
   endfunction

   function automatic char_row_type char_row(logic [nls_pkg::CHAR_W-1:0] c, logic e);
      char_row_type r;
      r = '0;
      r.ch  = c;
      r.eoi = e;
      return r;
   endfunction

   function automatic char_row_type checked_row(logic [nls_pkg::CHAR_W-1:0] c, logic e,
                                                literal_type w);
      char_row_type r;
      r = char_row(c, e);
      r.typed = 1'b1;
      r.want  = w;
      return r;
   endfunction

   function automatic logic [nls_pkg::CHAR_W-1:0] dec_char();
      return nls_pkg::CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [nls_pkg::CHAR_W-1:0] hex_char();
      int unsigned n;
      n = $urandom_range(0, 15);
      return (n < 10) ? nls_pkg::CH_ZERO + 8'(n) : nls_pkg::CH_LOW_A + 8'(n - 10);
   endfunction

   function automatic logic [nls_pkg::CHAR_W-1:0] any_char();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic append_row(char_row_type row);
      char_stream = {char_stream, row};
   endtask

   task automatic expect_literal(literal_type lit);
      pending_literals = {pending_literals, lit};
   endtask

   task automatic put_char(logic [nls_pkg::CHAR_W-1:0] c, logic e);
      append_row(char_row(c, e));
   endtask

   task automatic add_random_literal();
      int unsigned kind;
      int unsigned n;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            n = $urandom_range(1, 20);
            repeat (n) begin
               put_char(($urandom_range(0, 5) == 0) ? nls_pkg::CH_UNDER : dec_char(), 1'b0);
            end
         end
         2: begin
            put_char(nls_pkg::CH_ZERO, 1'b0);
            put_char(nls_pkg::CH_LOW_X, 1'b0);
            n = $urandom_range(1, 20);
            repeat (n) begin
               put_char(($urandom_range(0, 7) == 0) ? nls_pkg::CH_UNDER : hex_char(), 1'b0);
            end
         end
         3: begin
            put_char(nls_pkg::CH_ZERO, 1'b0);
            put_char(nls_pkg::CH_LOW_B, 1'b0);
            n = $urandom_range(1, 70);
            repeat (n) begin
               put_char(($urandom_range(0, 7) == 0) ? nls_pkg::CH_UNDER
                        : nls_pkg::CH_ZERO + 8'($urandom_range(0, 1)), 1'b0);
            end
         end
         4, 5: begin
            n = $urandom_range(1, 4);
            repeat (n) put_char(dec_char(), 1'b0);
            put_char(nls_pkg::CH_DOT, 1'b0);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
            repeat (n) put_char(dec_char(), 1'b0);
         end
         6: begin
            n = $urandom_range(1, 4);
            repeat (n) put_char(any_char(), ($urandom_range(0, 7) == 0));
         end
         7: begin
            put_char(nls_pkg::CH_ZERO, 1'b0);
            put_char(($urandom_range(0, 1) == 0) ? nls_pkg::CH_LOW_B : nls_pkg::CH_LOW_X,
                     1'b0);
            n = $urandom_range(0, 3);
            repeat (n) put_char(nls_pkg::CH_ZERO + 8'($urandom_range(0, 1)), 1'b0);
            put_char(any_char(), 1'b0);
         end
         8: begin
            n = $urandom_range(1, 3);
            repeat (n) put_char(dec_char(), 1'b0);
            put_char(nls_pkg::CH_DOT, 1'b0);
         end
         default: begin
            n = $urandom_range(1, 3);
            repeat (n) put_char(dec_char(), 1'b0);
            put_char(nls_pkg::CH_LOW_A + 8'($urandom_range(0, 5)), 1'b0);
         end
      endcase
      put_char(any_char(), ($urandom_range(0, 4) == 0));
   endtask

   task automatic compare_literal(literal_type want, literal_type got);
      if (got.value !== want.value) begin
         $error("value: expected %0d, got %0d", want.value, got.value);
         mismatches++;
      end
      if (got.frac_digits !== want.frac_digits) begin
         $error("frac_digits: expected %0d, got %0d", want.frac_digits, got.frac_digits);
         mismatches++;
      end
      if (got.is_fixed !== want.is_fixed) begin
         $error("is_fixed: expected %0d, got %0d", want.is_fixed, got.is_fixed);
         mismatches++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         mismatches++;
      end
      if (got.give_back !== want.give_back) begin
         $error("give_back: expected %0d, got %0d", want.give_back, got.give_back);
         mismatches++;
      end
   endtask

   initial begin
      char_row_type it;
      literal_type  lit;
      bit           produced;
      int unsigned  gap;
      int unsigned  waited;
      directed_rows = '{
         char_row(8'h00, 1'b1),
         checked_row(8'hFF, 1'b0, ok_literal(64'sd0, nls_pkg::GIVE_TERM)),
         char_row(nls_pkg::CH_ZERO, 1'b0),
         checked_row(8'h00, 1'b1, ok_literal(64'sd0, nls_pkg::GIVE_NONE)),
         checked_row(nls_pkg::CH_LOW_A, 1'b0, bad_literal(nls_pkg::STATUS_BAD_DIGIT)),
         char_row(nls_pkg::CH_ZERO, 1'b0),
         char_row(nls_pkg::CH_LOW_B, 1'b0),
         checked_row("2", 1'b0, bad_literal(nls_pkg::STATUS_BAD_DIGIT)),
         char_row(nls_pkg::CH_ZERO, 1'b0),
         char_row(nls_pkg::CH_LOW_X, 1'b0),
         char_row(nls_pkg::CH_LOW_F, 1'b0),
         checked_row(8'h00, 1'b0, ok_literal(64'sd15, nls_pkg::GIVE_TERM)),
         char_row("1", 1'b0),
         char_row(nls_pkg::CH_UNDER, 1'b0),
         char_row("2", 1'b0),
         char_row(nls_pkg::CH_DOT, 1'b0),
         char_row("5", 1'b0),
         char_row(nls_pkg::CH_UNDER, 1'b0),
         char_row("7", 1'b0),
         char_row(nls_pkg::CH_DOT, 1'b0),
         checked_row(nls_pkg::CH_UNDER, 1'b0, ok_literal(64'sd7, nls_pkg::GIVE_DOT)),
         char_row(nls_pkg::CH_DOT, 1'b0),
         checked_row(8'hFF, 1'b1, ok_literal(64'sd0, nls_pkg::GIVE_TERM))
      };
      foreach (directed_rows[k]) append_row(directed_rows[k]);
      while (char_stream.size() < DIRECTED_N + RANDOM_ITEMS) add_random_literal();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < char_stream.size(); i++) begin
         it = char_stream[i];
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_literals.size() != 0) @(posedge clock);
         end else begin
            gap = idle_cycles(tx_calm);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_ch           <= it.ch;
         req_end_of_input <= it.eoi;
         req_valid        <= 1'b1;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         produced = scan_char(it.ch, it.eoi, lit);
         if (it.typed) expect_literal(it.want);
         else if (produced) expect_literal(lit);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending_literals.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_literals.size() != 0) begin
         $error("%0d expected results never arrived", pending_literals.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      literal_type got;
      int unsigned hold;
      int unsigned seen;
      seen = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            got.value       = rsp_value;
            got.frac_digits = rsp_frac_digits;
            got.is_fixed    = rsp_is_fixed;
            got.status      = rsp_status;
            got.give_back   = rsp_give_back;
            if (pending_literals.size() == 0) begin
               $error("result with nothing expected: value %0d status %0d",
                      rsp_value, rsp_status);
               mismatches++;
            end else begin
               compare_literal(pending_literals.pop_front(), got);
            end
            seen++;
            hold = (seen == 25) ? LONG_HOLD : idle_cycles(rx_calm);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
